// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry concurrent checks.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/wvd_pkg.sv =====
// Types and constants of the wind vane direction decoder.
// Used by the result interface, the divider and match cells and the top level.
package wvd_pkg;

  localparam int ExtBits    = 17;
  localparam int MarginBits = 16;
  localparam int ResBits    = 29;
  localparam int IdxBits    = 4;
  localparam int StatusBits = 2;
  localparam int AddrBits   = 3;
  localparam int DataBits   = 32;
  localparam int LadderSize = 16;

  localparam logic [ResBits-1:0]    ResMax         = {ResBits{1'b1}};
  localparam logic [ExtBits-1:0]    ExtResetVal    = 17'd20000;
  localparam logic [MarginBits-1:0] MarginResetVal = 16'd5000;

  // Register indexes, taken from paddr[2].
  localparam logic RegExtResistor = 1'b0;
  localparam logic RegMatchMargin = 1'b1;

  // Result status codes.
  localparam logic [StatusBits-1:0] StatusMatched = 2'd0;
  localparam logic [StatusBits-1:0] StatusNoMatch = 2'd1;
  localparam logic [StatusBits-1:0] StatusZero    = 2'd2;

  // Nominal vane resistances in ohms, by compass sector.
  localparam logic [ExtBits-1:0] LadderOhms [LadderSize] = '{
    17'd33000, 17'd6570,  17'd8200,   17'd891,
    17'd1000,  17'd688,   17'd2200,   17'd1410,
    17'd3900,  17'd3140,  17'd16000,  17'd14120,
    17'd120000, 17'd42120, 17'd64900, 17'd21880
  };

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic valid;
    logic zero;
  } pipe_ctl_t;

endpackage

// ===== rtl/core/wvd_if.sv =====
// Valid/ready stream interfaces for the sample and result words.
// Depends on wvd_pkg for the result field widths.
interface wvd_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface wvd_out_if;
  import wvd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [IdxBits-1:0]    direction_index;
  logic [StatusBits-1:0] status;
  logic [ResBits-1:0]    resistance_ohms;

  modport source (output valid, output direction_index, output status,
                  output resistance_ohms, input ready);
  modport sink (input valid, input direction_index, input status,
                input resistance_ohms, output ready);
endinterface

// ===== rtl/core/wvd_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per word and
// hands remainder, numerator and quotient to the next cell. Uses wvd_pkg.
module wvd_div_cell #(
  parameter int SB = 12,
  parameter int NB = 29
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  wvd_pkg::pipe_ctl_t  ctl_i,
  input  logic [SB-1:0]       divisor_i,
  input  logic [SB-1:0]       rem_i,
  input  logic [NB-1:0]       num_i,
  input  logic [NB-1:0]       quo_i,
  output wvd_pkg::pipe_ctl_t  ctl_o,
  output logic [SB-1:0]       divisor_o,
  output logic [SB-1:0]       rem_o,
  output logic [NB-1:0]       num_o,
  output logic [NB-1:0]       quo_o
);
  import wvd_pkg::*;

  logic [SB:0]   trial;
  logic [SB:0]   diff;
  logic          ge;
  pipe_ctl_t     ctl_q;
  logic [SB-1:0] divisor_q, rem_q, rem_d;
  logic [NB-1:0] num_q, quo_q;

  assign trial = {rem_i, num_i[NB-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};
  // The remainder stays below the divisor, so the low bits hold it exactly.
  assign rem_d = ge ? diff[SB-1:0] : trial[SB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      divisor_q <= divisor_i;
      rem_q     <= rem_d;
      num_q     <= {num_i[NB-2:0], 1'b0};
      quo_q     <= {quo_i[NB-2:0], ge};
    end
  end

  assign ctl_o     = ctl_q;
  assign divisor_o = divisor_q;
  assign rem_o     = rem_q;
  assign num_o     = num_q;
  assign quo_o     = quo_q;
endmodule

// ===== rtl/core/wvd_match_cell.sv =====
// One ladder compare cell: checks the resistance against one table entry
// and keeps the closest entry so far. Uses wvd_pkg for the ladder table.
module wvd_match_cell #(
  parameter int Index = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  wvd_pkg::pipe_ctl_t                ctl_i,
  input  logic [wvd_pkg::ResBits-1:0]       res_i,
  input  logic [wvd_pkg::MarginBits-1:0]    best_i,
  input  logic [wvd_pkg::IdxBits-1:0]       idx_i,
  input  logic                              found_i,
  output wvd_pkg::pipe_ctl_t                ctl_o,
  output logic [wvd_pkg::ResBits-1:0]       res_o,
  output logic [wvd_pkg::MarginBits-1:0]    best_o,
  output logic [wvd_pkg::IdxBits-1:0]       idx_o,
  output logic                              found_o
);
  import wvd_pkg::*;

  localparam logic [IdxBits-1:0] Idx = IdxBits'(Index);
  localparam logic [ResBits-1:0] Target = ResBits'(LadderOhms[Idx]);

  logic [ResBits-1:0]    gap;
  logic                  hit;
  pipe_ctl_t             ctl_q;
  logic [ResBits-1:0]    res_q;
  logic [MarginBits-1:0] best_q;
  logic [IdxBits-1:0]    idx_q;
  logic                  found_q;

  assign gap = (res_i >= Target) ? (res_i - Target) : (Target - res_i);
  // Strictly closer wins, so on a tie the earlier entry is kept.
  assign hit = gap < ResBits'(best_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q   <= res_i;
      best_q  <= hit ? gap[MarginBits-1:0] : best_i;
      idx_q   <= hit ? Idx : idx_i;
      found_q <= hit | found_i;
    end
  end

  assign ctl_o   = ctl_q;
  assign res_o   = res_q;
  assign best_o  = best_q;
  assign idx_o   = idx_q;
  assign found_o = found_q;
endmodule

// ===== rtl/core/wind_vane_direction_decode.sv =====
// Wind vane direction decoder: top level with skid stage, divider chain,
// ladder match chain and APB registers. Depends on wvd_pkg, wvd_if,
// wvd_div_cell, wvd_match_cell and assert_macros.svh.

// One ADC sample enters per cycle while the result side does not stall. One
// entry register forms external_resistor * (2^SAMPLE_BITS - 1), a chain of
// 17 + SAMPLE_BITS division cells yields one quotient bit each, one register
// subtracts the resistor and saturates to 29 bits, and one compare cell for
// each of the first min(TABLE_ENTRIES, 16) ladder entries tracks the nearest
// sector before the output register. When the result side stalls the whole
// pipeline holds, and a one-word skid register still takes one more sample.
// Registers (APB, byte address 4*i): 0 is external_resistor, 1 is
// match_margin; write them only while idle.
`include "assert_macros.svh"

module wind_vane_direction_decode #(
  parameter int TABLE_ENTRIES = 16,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  wvd_in_if.sink                            sample_i,
  wvd_out_if.source                         result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wvd_pkg::AddrBits-1:0]      paddr,
  input  logic [wvd_pkg::DataBits-1:0]      pwdata,
  output logic [wvd_pkg::DataBits-1:0]      prdata,
  output logic                              pready
);
  import wvd_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int NB = ExtBits + SAMPLE_BITS;
  localparam int NM = (TABLE_ENTRIES < LadderSize) ? TABLE_ENTRIES : LadderSize;
  localparam int XW = (NB > ResBits) ? NB : ResBits;

  // Configuration registers.
  logic [ExtBits-1:0]    ext_q;
  logic [MarginBits-1:0] margin_q;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q    <= ExtResetVal;
      margin_q <= MarginResetVal;
    end else if (cfg_wr) begin
      if (paddr[2] == RegExtResistor) begin
        ext_q <= pwdata[ExtBits-1:0];
      end else begin
        margin_q <= pwdata[MarginBits-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == RegMatchMargin) ? DataBits'(margin_q) : DataBits'(ext_q);

  // Pipeline advance and input skid register.
  logic          en;
  logic          out_valid_q;
  logic          skid_valid_q, skid_valid_d;
  logic [SB-1:0] skid_q;
  logic          in_fire;
  logic          entry_valid;
  logic [SB-1:0] entry_sample;

  assign en             = !out_valid_q || result_o.ready;
  assign sample_i.ready = !skid_valid_q;
  assign in_fire        = sample_i.valid && !skid_valid_q;
  assign entry_valid    = skid_valid_q || in_fire;
  assign entry_sample   = skid_valid_q ? skid_q : sample_i.adc_sample;
  assign skid_valid_d   = en ? 1'b0 : (skid_valid_q || in_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_fire) begin
      skid_q <= sample_i.adc_sample;
    end
  end

  // Entry stage: numerator = resistor * full scale, as a shift and subtract.
  pipe_ctl_t     ctl0_q;
  logic [SB-1:0] div0_q;
  logic [NB-1:0] num0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else if (en) begin
      ctl0_q.valid <= entry_valid;
      ctl0_q.zero  <= (entry_sample == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div0_q <= entry_sample;
      num0_q <= {ext_q, {SB{1'b0}}} - NB'(ext_q);
    end
  end

  // Division chain, one quotient bit per cell, most significant first.
  pipe_ctl_t     dctl [NB+1];
  logic [SB-1:0] ddiv [NB+1];
  logic [SB-1:0] drem [NB+1];
  logic [NB-1:0] dnum [NB+1];
  logic [NB-1:0] dquo [NB+1];

  assign dctl[0] = ctl0_q;
  assign ddiv[0] = div0_q;
  assign drem[0] = '0;
  assign dnum[0] = num0_q;
  assign dquo[0] = '0;

  for (genvar g = 0; g < NB; g++) begin : g_div
    wvd_div_cell #(
      .SB(SB),
      .NB(NB)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .ctl_i    (dctl[g]),
      .divisor_i(ddiv[g]),
      .rem_i    (drem[g]),
      .num_i    (dnum[g]),
      .quo_i    (dquo[g]),
      .ctl_o    (dctl[g+1]),
      .divisor_o(ddiv[g+1]),
      .rem_o    (drem[g+1]),
      .num_o    (dnum[g+1]),
      .quo_o    (dquo[g+1])
    );
  end

  // Resistance stage: the quotient is never below the resistor.
  logic [XW-1:0]      res_full;
  pipe_ctl_t          rctl_q;
  logic [ResBits-1:0] res_q;

  assign res_full = XW'(dquo[NB]) - XW'(ext_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rctl_q <= '0;
    end else if (en) begin
      rctl_q <= dctl[NB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= (res_full > XW'(ResMax)) ? ResMax : res_full[ResBits-1:0];
    end
  end

  // Ladder match chain.
  pipe_ctl_t             mctl   [NM+1];
  logic [ResBits-1:0]    mres   [NM+1];
  logic [MarginBits-1:0] mbest  [NM+1];
  logic [IdxBits-1:0]    midx   [NM+1];
  logic                  mfound [NM+1];

  assign mctl[0]   = rctl_q;
  assign mres[0]   = res_q;
  assign mbest[0]  = margin_q;
  assign midx[0]   = '0;
  assign mfound[0] = 1'b0;

  for (genvar g = 0; g < NM; g++) begin : g_match
    wvd_match_cell #(
      .Index(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (mctl[g]),
      .res_i  (mres[g]),
      .best_i (mbest[g]),
      .idx_i  (midx[g]),
      .found_i(mfound[g]),
      .ctl_o  (mctl[g+1]),
      .res_o  (mres[g+1]),
      .best_o (mbest[g+1]),
      .idx_o  (midx[g+1]),
      .found_o(mfound[g+1])
    );
  end

  // Output register.
  logic [IdxBits-1:0]    out_idx_q;
  logic [StatusBits-1:0] out_status_q;
  logic [ResBits-1:0]    out_res_q;
  pipe_ctl_t             last_ctl;

  assign last_ctl = mctl[NM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (last_ctl.zero) begin
        out_idx_q    <= '0;
        out_status_q <= StatusZero;
        out_res_q    <= '0;
      end else begin
        out_idx_q    <= mfound[NM] ? midx[NM] : '0;
        out_status_q <= mfound[NM] ? StatusMatched : StatusNoMatch;
        out_res_q    <= mres[NM];
      end
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.direction_index = out_idx_q;
  assign result_o.status          = out_status_q;
  assign result_o.resistance_ohms = out_res_q;

  // A zero reading carries neither a sector nor a resistance.
  `ASSERT_IMPLIES(a_zero_clean, clk_i, rst_ni,
    out_valid_q && (out_status_q == StatusZero),
    (out_res_q == '0) && (out_idx_q == '0))
  // Only a matched word names a sector.
  `ASSERT_IMPLIES(a_idx_only_matched, clk_i, rst_ni,
    out_valid_q && (out_status_q != StatusMatched), out_idx_q == '0)
  // A parked sample survives a stall.
  `ASSERT_NEXT(a_skid_hold, clk_i, rst_ni, skid_valid_q && !en, skid_valid_q)
  // A result stalled at the output is not overwritten.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !result_o.ready,
    out_valid_q && $stable(out_res_q) && $stable(out_status_q))
endmodule
